// ===== src/ssps_pkg.sv =====
// Package for the sparse set payload store.
// Holds the default sizes, the opcode codes and the sequencer state type.
// No dependencies.
package ssps_pkg;

	localparam int CAPACITY_DEF     = 256;
	localparam int PAYLOAD_BITS_DEF = 32;

	typedef enum logic {
		OP_LOOKUP = 1'b0,
		OP_WRITE  = 1'b1
	} opcode_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DENSE,
		ST_CHECK,
		ST_CLEAR
	} state_t;

endpackage

// ===== src/sparse_set_payload_store.sv =====
// Sparse set of indices with one payload per member, kept in three memories.
// Depends on ssps_pkg for default sizes, opcodes and the sequencer state type.
//
// Use: drive opcode, key_index and write_data with start high; the request is
// taken at a rising edge where start is high and busy is low. A lookup
// (OP_LOOKUP) reports whether the index is a member and its payload; a write
// (OP_WRITE) stores the payload if the index is a member or there is room,
// appending the index to the dense list if it is not yet a member. Every
// request gives exactly one result, shown on present, read_data and
// member_count for one cycle with done high. The request passes through the
// DENSE and CHECK states with busy high, so a new request is taken only once
// the last one has left CHECK. This is set by two dependent reads of
// registered memories: the back pointer, then the dense entry it points at,
// then the compare and the write-back.
// Reset: clears the member count and the sequencer, then sweeps the back
// pointer memory to zero, one entry a cycle, over all CAPACITY entries (256
// by default) with busy high. The dense and payload memories need no clearing;
// membership is decided by the back pointer lying below the count and the
// dense entry matching the index.
// The receiver cannot stall; each result is valid for its single done cycle.
module sparse_set_payload_store
	import ssps_pkg::*;
#(
	parameter int CAPACITY     = CAPACITY_DEF,
	parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        opcode,
	input  logic [7:0]  key_index,
	input  logic [31:0] write_data,
	output logic        done,
	output logic        present,
	output logic [31:0] read_data,
	output logic [8:0]  member_count
);

	localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);

	logic [7:0]              bp_mem    [CAPACITY];
	logic [7:0]              dense_mem [CAPACITY];
	logic [PAYLOAD_BITS-1:0] pay_mem   [CAPACITY];

	state_t state_q, state_d;

	logic                    accept;
	logic                    dense_rd_en;
	logic                    check_en;
	logic                    clr_en;

	opcode_t                 op_q;
	logic [7:0]              key_q;
	logic                    key_ok_q;
	logic [PAYLOAD_BITS-1:0] data_q;
	logic [IW-1:0]           key_addr_q;
	logic [7:0]              bp_rd_q;
	logic [7:0]              dense_rd_q;
	logic [PAYLOAD_BITS-1:0] pay_rd_q;
	logic [CW-1:0]           count_q;
	logic [IW-1:0]           clr_q;

	logic [IW+7:0]           key_ext;
	logic [63:0]             data_ext;
	logic [63:0]             pay_ext;
	logic [IW+7:0]           bp_ext;
	logic [CW+8:0]           count_ext;
	logic [CW+7:0]           bp_cmp;
	logic [CW+7:0]           count_cmp;

	logic                    is_member;
	logic                    room;
	logic                    ins_en;
	logic                    pay_we;

	assign accept    = start && !busy;
	assign key_ext   = (IW + 8)'(key_index);
	assign data_ext  = 64'(write_data);
	assign pay_ext   = 64'(pay_rd_q);
	assign bp_ext    = (IW + 8)'(bp_rd_q);
	assign count_ext = (CW + 9)'(count_q);
	assign bp_cmp    = (CW + 8)'(bp_rd_q);
	assign count_cmp = (CW + 8)'(count_q);

	assign is_member = key_ok_q && (bp_cmp < count_cmp) && (dense_rd_q == key_q);
	assign room      = 32'(count_q) < CAPACITY;
	assign ins_en    = check_en && (op_q == OP_WRITE) && key_ok_q && !is_member && room;
	assign pay_we    = check_en && (op_q == OP_WRITE) && key_ok_q && (is_member || room);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (accept) state_d = ST_DENSE;
			ST_DENSE: state_d = ST_CHECK;
			ST_CHECK: state_d = ST_IDLE;
			ST_CLEAR: if (clr_q == IW'(CAPACITY - 1)) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		busy        = 1'b1;
		dense_rd_en = 1'b0;
		check_en    = 1'b0;
		clr_en      = 1'b0;
		case (state_q)
			ST_IDLE:  busy = 1'b0;
			ST_DENSE: dense_rd_en = 1'b1;
			ST_CHECK: check_en = 1'b1;
			ST_CLEAR: clr_en = 1'b1;
			default:  busy = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// hold the request
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q       <= opcode_t'(opcode);
			key_q      <= key_index;
			key_ok_q   <= 32'(key_index) < CAPACITY;
			key_addr_q <= key_ext[IW-1:0];
			data_q     <= data_ext[PAYLOAD_BITS-1:0];
		end
	end

	// back pointer memory
	always_ff @(posedge clk) begin
		if (accept) begin
			bp_rd_q <= bp_mem[key_ext[IW-1:0]];
		end
		if (clr_en) begin
			bp_mem[clr_q] <= '0;
		end else if (ins_en) begin
			bp_mem[key_addr_q] <= 8'(count_q);
		end
	end

	// dense member memory
	always_ff @(posedge clk) begin
		if (dense_rd_en) begin
			dense_rd_q <= dense_mem[bp_ext[IW-1:0]];
		end
		if (ins_en) begin
			dense_mem[count_q[IW-1:0]] <= key_q;
		end
	end

	// payload memory
	always_ff @(posedge clk) begin
		if (accept) begin
			pay_rd_q <= pay_mem[key_ext[IW-1:0]];
		end
		if (pay_we) begin
			pay_mem[key_addr_q] <= data_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			clr_q   <= '0;
			done    <= 1'b0;
		end else begin
			done <= check_en;
			if (clr_en) begin
				clr_q <= clr_q + IW'(1);
			end
			if (ins_en) begin
				count_q <= count_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (check_en) begin
			present      <= is_member;
			read_data    <= (is_member && (op_q == OP_LOOKUP)) ? pay_ext[31:0] : 32'd0;
			member_count <= ins_en ? 9'(count_ext + (CW + 9)'(1)) : count_ext[8:0];
		end
	end

endmodule
